>>> rtl/core/lsfb_pkg.sv
`default_nettype none

package lsfb_pkg;

	localparam int LED_COUNT_DEF = 32;
	localparam int END_WORDS_DEF = 1;

	localparam logic [7:0] BRIGHT_HEAD = 8'hE0;

	typedef enum logic [1:0] {
		CMD_SET_ONE   = 2'd0,
		CMD_SET_ALL   = 2'd1,
		CMD_SWAP_EMIT = 2'd2,
		CMD_REEMIT    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		WK_START,
		WK_LED,
		WK_END
	} word_kind_t;

	// level*31/255 via x/255 = (x + 1 + (x >> 8)) >> 8, exact for x below 65535
	function automatic logic [31:0] led_word(input logic [7:0] red, input logic [7:0] green,
		input logic [7:0] blue, input logic [7:0] level);
		logic [12:0] prod;
		logic [13:0] sum;
		logic [4:0]  scaled;
		prod   = 13'({5'd0, level} * 13'd31);
		sum    = {1'b0, prod} + 14'd1 + {9'd0, prod[12:8]};
		scaled = sum[12:8];
		return {BRIGHT_HEAD | {3'b000, scaled}, blue, green, red};
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/lsfb_ifs.sv
`default_nettype none

interface lsfb_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] led_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] level;

	modport source (
		output valid, cmd, led_index, red, green, blue, level,
		input  ready
	);
	modport sink (
		input  valid, cmd, led_index, red, green, blue, level,
		output ready
	);
endinterface

interface lsfb_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_word;
	logic        last_word;

	modport source (
		output valid, frame_word, last_word,
		input  ready
	);
	modport sink (
		input  valid, frame_word, last_word,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/led_strip_frame_builder_core.sv
// set one LED: ready again the cycle after acceptance
// set all LEDs: one store write per cycle through the single write port
// emit: 1 + LED_COUNT + END_WORDS words, one per cycle unless frame.ready stalls, LED words from the store read port,
//   each word through the stage-1 and output registers, ready again once the last word is read
// reset (arst_n, async): both stores read as zero through per-entry valid bits, store zero
//   active, fill byte 0xFF; no clearing pass
`default_nettype none

module led_strip_frame_builder_core #(
	parameter int LED_COUNT = lsfb_pkg::LED_COUNT_DEF,
	parameter int END_WORDS = lsfb_pkg::END_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	lsfb_cmd_if.sink         command,
	lsfb_word_if.source      frame
);
	import lsfb_pkg::*;

	localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int ADDR_W    = IDX_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam int WORDS     = 1 + LED_COUNT + END_WORDS;
	localparam int POS_W     = $clog2(WORDS + 1);

	localparam logic [POS_W-1:0] POS_LAST_LED = POS_W'(LED_COUNT);
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(WORDS - 1);
	localparam logic [POS_W-1:0] FILL_LAST    = POS_W'(LED_COUNT - 1);

	state_t state_q, state_d;
	logic [POS_W-1:0]     pos_q;
	logic                 active_q;
	logic [7:0]           fill_q;
	logic [31:0]          word_q;
	logic [31:0]          mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;

	logic [31:0] rd_data_s1;
	logic        rd_ok_s1;
	word_kind_t  kind_s1;
	logic        last_s1;
	logic        busy_s1;

	logic [31:0] out_word_q;
	logic        out_last_q;
	logic        out_valid_q;

	logic              accept;
	cmd_t              in_cmd;
	logic [31:0]       new_word;
	logic              idx_ok;
	logic              s1_adv;
	logic              issue;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [31:0]       mem_wdata;
	logic [POS_W-1:0]  led_pos;
	logic [ADDR_W-1:0] mem_raddr;
	word_kind_t        kind_d;
	logic [31:0]       sel_word;

	assign accept   = command.valid && command.ready;
	assign in_cmd   = cmd_t'(command.cmd);
	assign new_word = led_word(command.red, command.green, command.blue, command.level);
	assign idx_ok   = command.led_index < 8'(LED_COUNT);
	assign s1_adv   = busy_s1 && (!out_valid_q || frame.ready);
	assign led_pos  = pos_q - POS_W'(1);
	assign mem_raddr = {active_q, led_pos[IDX_W-1:0]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd) inside
						CMD_SET_ALL: state_d = ST_FILL;
						CMD_SWAP_EMIT, CMD_REEMIT: state_d = ST_EMIT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				if (pos_q == FILL_LAST) state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (issue && pos_q == POS_LAST) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		command.ready = 1'b0;
		issue         = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = {~active_q, command.led_index[IDX_W-1:0]};
		mem_wdata     = new_word;
		unique case (state_q)
			ST_IDLE: begin
				command.ready = 1'b1;
				mem_we        = accept && (in_cmd == CMD_SET_ONE) && idx_ok;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = {~active_q, pos_q[IDX_W-1:0]};
				mem_wdata = word_q;
			end
			ST_EMIT: begin
				issue = !busy_s1 || s1_adv;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (pos_q == '0) kind_d = WK_START;
		else if (pos_q <= POS_LAST_LED) kind_d = WK_LED;
		else kind_d = WK_END;
	end

	always_comb begin
		case (kind_s1)
			WK_START: sel_word = '0;
			WK_LED:   sel_word = rd_ok_s1 ? rd_data_s1 : '0;
			WK_END:   sel_word = {4{fill_q}};
			default:  sel_word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			active_q    <= 1'b0;
			fill_q      <= 8'hFF;
			valid_q     <= '0;
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) pos_q <= '0;
			else if (state_q == ST_FILL || issue) pos_q <= pos_q + POS_W'(1);
			if (accept && in_cmd == CMD_SWAP_EMIT) active_q <= ~active_q;
			if (cfg_we) fill_q <= cfg_wdata;
			if (mem_we) valid_q[mem_waddr] <= 1'b1;
			if (issue) busy_s1 <= 1'b1;
			else if (s1_adv) busy_s1 <= 1'b0;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (frame.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_cmd == CMD_SET_ALL) word_q <= new_word;
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (issue) begin
			rd_data_s1 <= mem_q[mem_raddr];
			rd_ok_s1   <= valid_q[mem_raddr];
			kind_s1    <= kind_d;
			last_s1    <= (pos_q == POS_LAST);
		end
		if (s1_adv) begin
			out_word_q <= sel_word;
			out_last_q <= last_s1;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_word = out_word_q;
	assign frame.last_word  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/lsfb_checker.sv
`default_nettype none

module lsfb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic [1:0]  cmd_code,
	input wire logic        word_valid,
	input wire logic        word_ready,
	input wire logic [31:0] word_data,
	input wire logic        word_last
);
	import lsfb_pkg::*;

	// a fill sweep keeps the block busy past the accepting cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_code == 2'(CMD_SET_ALL)) |=> !cmd_ready)
		else $error("ready high right after a set-all item");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready &&
		((cmd_code == 2'(CMD_SWAP_EMIT)) || (cmd_code == 2'(CMD_REEMIT))) |=> !cmd_ready)
		else $error("ready high right after an emit item");

	// end words repeat one fill byte
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_last |->
		(word_data[31:24] == word_data[7:0]) && (word_data[23:16] == word_data[7:0]) &&
		(word_data[15:8] == word_data[7:0]))
		else $error("last word is not a repeated fill byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(word_data) && $stable(word_last))
		else $error("stalled output item changed");

endmodule

bind led_strip_frame_builder_core lsfb_checker u_lsfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (command.valid),
	.cmd_ready  (command.ready),
	.cmd_code   (command.cmd),
	.word_valid (frame.valid),
	.word_ready (frame.ready),
	.word_data  (frame.frame_word),
	.word_last  (frame.last_word)
);

`default_nettype wire

>>> tb/led_strip_frame_builder_core_test.sv
`default_nettype none

module led_strip_frame_builder_core_test;
	import lsfb_pkg::*;

	localparam int NUM_LEDS      = LED_COUNT_DEF;
	localparam int NUM_END       = END_WORDS_DEF;
	localparam int SETTLE_CYCLES = NUM_LEDS + 8;
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 50;

	class frame_scoreboard;
		bit [31:0] led_bank [2][NUM_LEDS];
		bit        shown_bank;
		bit [7:0]  fill_byte;
		bit [32:0] pending_words [$];
		int        errors;

		function new();
			foreach (led_bank[b, i])
				led_bank[b][i] = '0;
			shown_bank = 1'b0;
			fill_byte  = 8'hFF;
			errors     = 0;
		endfunction

		function void set_fill(bit [7:0] value);
			fill_byte = value;
		endfunction

		function void note_command(cmd_t op, bit [7:0] idx, bit [7:0] red, bit [7:0] green,
			bit [7:0] blue, bit [7:0] level);
			int unsigned scaled;
			bit [31:0]   led;
			scaled = level * 31 / 255;
			led    = {3'b111, scaled[4:0], blue, green, red};
			case (op)
				CMD_SET_ONE: begin
					if (idx < NUM_LEDS)
						led_bank[~shown_bank][idx] = led;
				end
				CMD_SET_ALL: begin
					for (int i = 0; i < NUM_LEDS; i++)
						led_bank[~shown_bank][i] = led;
				end
				default: begin
					if (op == CMD_SWAP_EMIT)
						shown_bank = ~shown_bank;
					pending_words.push_back({1'b0, 32'h0});
					for (int i = 0; i < NUM_LEDS; i++)
						pending_words.push_back({1'b0, led_bank[shown_bank][i]});
					// end words pick up the fill byte as it stands when the emit item is accepted
					for (int i = 0; i < NUM_END; i++)
						pending_words.push_back({i == NUM_END - 1, {4{fill_byte}}});
				end
			endcase
		endfunction

		function void check_word(bit [31:0] word, bit last);
			bit [32:0] want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected frame word %h last %b", $time, word, last);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			if (word != want[31:0]) begin
				$display("%0t: frame_word expected %h actual %h", $time, want[31:0], word);
				errors++;
			end
			if (last != want[32]) begin
				$display("%0t: last_word expected %b actual %b", $time, want[32], last);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	bit         no_idle;
	int         stall_count = 0;

	lsfb_cmd_if  cmd_ch();
	lsfb_word_if word_ch();

	frame_scoreboard sb = new();

	led_strip_frame_builder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.command   (cmd_ch),
		.frame     (word_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: ready changes on the falling edge
	initial begin
		word_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			word_ch.ready = no_idle || ($urandom_range(0, 99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_ch.valid && word_ch.ready)
			sb.check_word(word_ch.frame_word, word_ch.last_word);
		if ((cmd_ch.valid && cmd_ch.ready) || (word_ch.valid && word_ch.ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("led_strip_frame_builder_core test failed");
			$finish;
		end
	end

	// called on a falling edge, returns on the falling edge after acceptance
	task automatic send_command(input cmd_t op, input bit [7:0] idx, input bit [7:0] red,
		input bit [7:0] green, input bit [7:0] blue, input bit [7:0] level);
		while (!no_idle && $urandom_range(0, 99) < 37) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     = 1'b1;
		cmd_ch.cmd       = op;
		cmd_ch.led_index = idx;
		cmd_ch.red       = red;
		cmd_ch.green     = green;
		cmd_ch.blue      = blue;
		cmd_ch.level     = level;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(op, idx, red, green, blue, level);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_ch.valid = 1'b0;
		while (sb.pending_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic load_fill(input bit [7:0] value);
		wait_drained();
		// a set-all item leaves the block busy without any word to wait for
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_fill(value);
	endtask

	task automatic send_random();
		int        roll;
		bit [7:0]  idx;
		bit [7:0]  level;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			idx = 8'($urandom_range(0, 255));
		else
			idx = 8'($urandom_range(0, NUM_LEDS - 1));
		case ($urandom_range(0, 9))
			0:       level = 8'h00;
			1:       level = 8'hFF;
			default: level = 8'($urandom_range(0, 255));
		endcase
		if (roll < 45)
			send_command(CMD_SET_ONE, idx, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), level);
		else if (roll < 55)
			send_command(CMD_SET_ALL, idx, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), level);
		else if (roll < 78)
			send_command(CMD_SWAP_EMIT, idx, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), level);
		else
			send_command(CMD_REEMIT, idx, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), level);
	endtask

	initial begin
		bit [7:0] phase_fill [5];
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		no_idle          = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.cmd       = CMD_SET_ONE;
		cmd_ch.led_index = '0;
		cmd_ch.red       = '0;
		cmd_ch.green     = '0;
		cmd_ch.blue      = '0;
		cmd_ch.level     = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// cleared stores, default fill
		send_command(CMD_REEMIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_command(CMD_SWAP_EMIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_command(CMD_SET_ONE, 8'd0, 8'hFF, 8'h00, 8'hFF, 8'hFF);
		send_command(CMD_SET_ONE, 8'd31, 8'h00, 8'hFF, 8'h00, 8'h00);
		// out of range index leaves the store alone
		send_command(CMD_SET_ONE, 8'd32, 8'h11, 8'h22, 8'h33, 8'h44);
		send_command(CMD_SET_ONE, 8'd255, 8'h55, 8'h66, 8'h77, 8'h88);
		// brightness scaling around its steps
		send_command(CMD_SET_ONE, 8'd1, 8'h01, 8'h02, 8'h03, 8'd8);
		send_command(CMD_SET_ONE, 8'd2, 8'h04, 8'h05, 8'h06, 8'd9);
		send_command(CMD_SET_ONE, 8'd3, 8'h07, 8'h08, 8'h09, 8'd254);
		send_command(CMD_SWAP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_command(CMD_REEMIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		load_fill(8'h00);
		send_command(CMD_REEMIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_command(CMD_SET_ALL, 8'h00, 8'h12, 8'h34, 8'h56, 8'd128);
		send_command(CMD_SET_ONE, 8'd5, 8'hAA, 8'h55, 8'hAA, 8'd127);
		send_command(CMD_SWAP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		load_fill(8'hA5);
		send_command(CMD_SET_ALL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// the prepared store must not leak into the active frame
		send_command(CMD_REEMIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_command(CMD_SWAP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		phase_fill[0] = 8'hFF;
		phase_fill[1] = 8'($urandom_range(0, 255));
		phase_fill[2] = 8'h00;
		phase_fill[3] = 8'h3C;
		phase_fill[4] = 8'($urandom_range(0, 255));
		for (int p = 0; p < 5; p++) begin
			load_fill(phase_fill[p]);
			no_idle = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_random();
			end
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("led_strip_frame_builder_core test passed");
		else
			$display("led_strip_frame_builder_core test failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/lsfb_pkg.sv
rtl/core/lsfb_ifs.sv
rtl/core/led_strip_frame_builder_core.sv
rtl/core/lsfb_checker.sv
tb/led_strip_frame_builder_core_test.sv
